[src/min_max_normalizer_defines.svh]
// assertion macros used by the normalizer controller
`ifndef MIN_MAX_NORMALIZER_DEFINES_SVH
`define MIN_MAX_NORMALIZER_DEFINES_SVH

// assertion checked at every rising edge outside reset
`define MMN_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion checked at every rising edge, reset included
`define MMN_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/mmn_pkg.sv]
// package with types and constants of the min-max normalizer
package mmn_pkg;

  localparam int DEF_SAMPLE_BITS = 16;
  localparam int OP_BITS         = 2;
  localparam int OUT_BITS        = 16;
  localparam int QUOT_BITS       = 16;
  localparam int CNT_BITS        = $clog2(QUOT_BITS);

  localparam logic [OP_BITS-1:0] OP_CLEAR     = 2'd0;
  localparam logic [OP_BITS-1:0] OP_MEASURE   = 2'd1;
  localparam logic [OP_BITS-1:0] OP_NORMALIZE = 2'd2;

  localparam logic [OUT_BITS-1:0] NORM_MAX = {OUT_BITS{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic write;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_div;
  } dp_status_t;

endpackage

[src/mmn_ctrl.sv]
// controller state machine of the min-max normalizer
`include "min_max_normalizer_defines.svh"

module mmn_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  mmn_pkg::dp_status_t status,
  output mmn_pkg::ctrl_cmd_t  cmd
);
  import mmn_pkg::*;

  state_t               state_r, state_nxt;
  logic [CNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 last_step;

  assign last_step = (cnt_r == CNT_BITS'(QUOT_BITS - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = status.need_div ? ST_DIVIDE : ST_WRITE;
        end
      end
      ST_DIVIDE: begin
        if (last_step) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_DIVIDE: begin
        cmd.step = 1'b1;
      end
      ST_WRITE: begin
        cmd.write = !out_valid_r || out_tready;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.load) begin
      cnt_nxt = '0;
    end else if (cmd.step) begin
      cnt_nxt = cnt_r + CNT_BITS'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.write) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  `MMN_ASSERT(a_div_ends, clk, rst_n, (state_r == ST_DIVIDE && last_step) |=> (state_r == ST_WRITE), "divider did not finish after the last step")
  `MMN_ASSERT(a_div_starts_at_zero, clk, rst_n, (state_r == ST_DIVIDE && $past(state_r) == ST_IDLE) |-> (cnt_r == '0), "divider started with a stale count")
  `MMN_ASSERT(a_write_free_slot, clk, rst_n, (state_r == ST_WRITE && !out_valid_r) |=> (out_valid_r && state_r == ST_IDLE), "result not written into a free output slot")
  `MMN_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> (state_r == ST_IDLE && !out_valid_r), "reset did not clear the controller")

endmodule

[src/mmn_datapath.sv]
// datapath of the min-max normalizer: extremes, saturation and restoring divider
module mmn_datapath #(
  parameter int SAMPLE_BITS = mmn_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [mmn_pkg::OP_BITS-1:0]         opcode,
  input  logic signed [SAMPLE_BITS-1:0]       sample,
  input  mmn_pkg::ctrl_cmd_t                  cmd,
  output mmn_pkg::dp_status_t                 status,
  output logic [mmn_pkg::OUT_BITS-1:0]        normalized,
  output logic [mmn_pkg::OUT_BITS-1:0]        min_value,
  output logic [mmn_pkg::OUT_BITS-1:0]        range_value,
  output logic                                degenerate
);
  import mmn_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int NB = SB + QUOT_BITS;

  logic signed [SB-1:0] min_r, min_nxt;
  logic signed [SB-1:0] max_r, max_nxt;
  logic                 have_r, have_nxt;

  logic [OUT_BITS-1:0]  res_min_r, res_min_nxt;
  logic [OUT_BITS-1:0]  res_range_r, res_range_nxt;
  logic                 res_degen_r, res_degen_nxt;

  logic [SB-1:0]        rem_r, rem_nxt;
  logic [QUOT_BITS-1:0] low_r, low_nxt;
  logic [SB-1:0]        div_r, div_nxt;
  logic [QUOT_BITS-1:0] quo_r, quo_nxt;

  logic [OUT_BITS-1:0]  norm_out_r, min_out_r, range_out_r;
  logic                 degen_out_r;

  logic signed [SB:0]   diff;
  logic signed [SB:0]   range_cur;
  logic signed [SB:0]   range_new;
  logic                 degen_cur;
  logic                 diff_low;
  logic                 diff_high;
  logic [NB-1:0]        prod;
  logic [SB+16:0]       min_ext;
  logic [SB+16:0]       range_ext;
  logic [SB:0]          trial;
  logic                 trial_ge;

  assign diff      = {sample[SB-1], sample} - {min_r[SB-1], min_r};
  assign range_cur = {max_r[SB-1], max_r} - {min_r[SB-1], min_r};
  assign degen_cur = !have_r || (range_cur == '0);
  assign diff_low  = diff[SB] || (diff == '0);
  assign diff_high = (diff >= range_cur);
  // diff * 65535 without a multiplier
  assign prod      = {diff[SB-1:0], {QUOT_BITS{1'b0}}} - {{QUOT_BITS{1'b0}}, diff[SB-1:0]};

  assign status.need_div = (opcode == OP_NORMALIZE) && !degen_cur && !diff_low && !diff_high;

  // running extremes
  always_comb begin
    min_nxt  = min_r;
    max_nxt  = max_r;
    have_nxt = have_r;
    case (opcode)
      OP_CLEAR: begin
        min_nxt  = '0;
        max_nxt  = '0;
        have_nxt = 1'b0;
      end
      OP_MEASURE: begin
        have_nxt = 1'b1;
        if (!have_r) begin
          min_nxt = sample;
          max_nxt = sample;
        end else begin
          if (sample < min_r) min_nxt = sample;
          if (sample > max_r) max_nxt = sample;
        end
      end
      default: begin
        min_nxt = min_r;
      end
    endcase
  end

  assign range_new = {max_nxt[SB-1], max_nxt} - {min_nxt[SB-1], min_nxt};
  assign min_ext   = {{17{min_nxt[SB-1]}}, min_nxt};
  assign range_ext = {16'b0, range_new};

  // one restoring step per cycle
  assign trial    = {rem_r, low_r[QUOT_BITS-1]};
  assign trial_ge = (trial >= {1'b0, div_r});

  always_comb begin
    res_min_nxt   = res_min_r;
    res_range_nxt = res_range_r;
    res_degen_nxt = res_degen_r;
    rem_nxt       = rem_r;
    low_nxt       = low_r;
    div_nxt       = div_r;
    quo_nxt       = quo_r;
    if (cmd.load) begin
      res_min_nxt   = min_ext[OUT_BITS-1:0];
      res_range_nxt = range_ext[OUT_BITS-1:0];
      res_degen_nxt = (opcode == OP_NORMALIZE) && degen_cur;
      rem_nxt       = prod[NB-1:QUOT_BITS];
      low_nxt       = prod[QUOT_BITS-1:0];
      div_nxt       = range_cur[SB-1:0];
      if (opcode == OP_NORMALIZE && !degen_cur && !diff_low && diff_high) begin
        quo_nxt = NORM_MAX;
      end else begin
        quo_nxt = '0;
      end
    end else if (cmd.step) begin
      rem_nxt = trial_ge ? SB'(trial - {1'b0, div_r}) : trial[SB-1:0];
      low_nxt = {low_r[QUOT_BITS-2:0], 1'b0};
      quo_nxt = {quo_r[QUOT_BITS-2:0], trial_ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r  <= '0;
      max_r  <= '0;
      have_r <= 1'b0;
    end else if (cmd.load) begin
      min_r  <= min_nxt;
      max_r  <= max_nxt;
      have_r <= have_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_min_r   <= res_min_nxt;
    res_range_r <= res_range_nxt;
    res_degen_r <= res_degen_nxt;
    rem_r       <= rem_nxt;
    low_r       <= low_nxt;
    div_r       <= div_nxt;
    quo_r       <= quo_nxt;
    if (cmd.write) begin
      norm_out_r  <= quo_r;
      min_out_r   <= res_min_r;
      range_out_r <= res_range_r;
      degen_out_r <= res_degen_r;
    end
  end

  assign normalized  = norm_out_r;
  assign min_value   = min_out_r;
  assign range_value = range_out_r;
  assign degenerate  = degen_out_r;

endmodule

[src/min_max_normalizer.sv]
// top level of the min-max normalizer
//
//  channel | direction | tdata (low bit up)                        | tuser
//  in_     | slave     | sample                                    | opcode
//  out_    | master    | normalized, min_value, range_value        | degenerate
//
// clear, measure, unused and non-dividing normalize items are accepted, then written out;
// normalize items needing a divide: accept, 16 restoring divider steps, output load
// only one word is in work at a time; the next word is taken while a result waits at out_
// rst_n is synchronous, active low, and clears the extremes and the handshake state
// a stalled out_ holds the result; the block then stops after finishing the next word
module min_max_normalizer #(
  parameter int SAMPLE_BITS = mmn_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    in_tdata,   // sample
  input  logic [mmn_pkg::OP_BITS-1:0]         in_tuser,   // opcode
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [3*mmn_pkg::OUT_BITS-1:0]      out_tdata,  // normalized, min_value, range_value
  output logic                                out_tuser   // degenerate
);
  import mmn_pkg::*;

  ctrl_cmd_t            cmd;
  dp_status_t           status;
  logic [OUT_BITS-1:0]  normalized;
  logic [OUT_BITS-1:0]  min_value;
  logic [OUT_BITS-1:0]  range_value;

  mmn_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  mmn_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .opcode      (in_tuser),
    .sample      (in_tdata[SAMPLE_BITS-1:0]),
    .cmd         (cmd),
    .status      (status),
    .normalized  (normalized),
    .min_value   (min_value),
    .range_value (range_value),
    .degenerate  (out_tuser)
  );

  assign out_tdata = {range_value, min_value, normalized};

endmodule

[verif/tb_top.sv]
// testbench of min_max_normalizer: directed table and random sequences, checked by a predictor
`timescale 1ns / 1ps

module tb_top;
  import mmn_pkg::*;

  localparam logic [OP_BITS-1:0] OP_RESERVED = 2'd3;
  localparam int RANDOM_WORDS = 900;
  localparam int HOLD_CYCLES  = 400;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DIR_ROWS     = 25;
  localparam int EXP_DEPTH    = 16;

  typedef struct packed {
    logic [15:0] norm;
    logic [15:0] min_v;
    logic [15:0] range_v;
    logic        degen;
  } nresult_t;

  typedef struct packed {
    logic [OP_BITS-1:0] op;
    logic [15:0]        smp;
    logic               typed;
    nresult_t           want;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [15:0]           in_tdata;   // sample
  logic [OP_BITS-1:0]    in_tuser;   // opcode
  logic                  out_tvalid;
  logic                  out_tready;
  logic [3*OUT_BITS-1:0] out_tdata;  // normalized, min_value, range_value
  logic                  out_tuser;  // degenerate

  // predictor state
  logic signed [15:0] lo_seen;
  logic signed [15:0] hi_seen;
  logic               seen_any;

  // expected words in flight, written at in_ and read at out_
  nresult_t exp_fifo [EXP_DEPTH];
  int       exp_wr;
  int       exp_rd;
  dir_row_t dir_rows [DIR_ROWS];
  int       mismatches;
  int       words_sent;
  int       cycle_cnt;
  int       hold_reqs;
  bit       idle_on;
  bit       rx_stall_on;

  min_max_normalizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("FAIL min_max_normalizer");
      $finish;
    end
  end

  function automatic nresult_t calc_normalized(logic [OP_BITS-1:0] op, logic signed [15:0] smp);
    nresult_t           r;
    logic signed [16:0] span;
    logic signed [16:0] diff;
    r = '0;
    case (op)
      OP_CLEAR: begin
        lo_seen  = '0;
        hi_seen  = '0;
        seen_any = 1'b0;
      end
      OP_MEASURE: begin
        if (!seen_any) begin
          lo_seen  = smp;
          hi_seen  = smp;
          seen_any = 1'b1;
        end else begin
          if (smp < lo_seen) lo_seen = smp;
          if (smp > hi_seen) hi_seen = smp;
        end
      end
      OP_NORMALIZE: begin
        span = {hi_seen[15], hi_seen} - {lo_seen[15], lo_seen};
        if (!seen_any || span <= 0) begin
          r.degen = 1'b1;
        end else begin
          diff = {smp[15], smp} - {lo_seen[15], lo_seen};
          if (diff <= 0) r.norm = '0;
          else if (diff >= span) r.norm = NORM_MAX;
          else r.norm = 16'(longint'(diff) * 65535 / longint'(span));
        end
      end
      default: ;
    endcase
    r.min_v   = lo_seen;
    r.range_v = hi_seen - lo_seen;
    return r;
  endfunction

  function automatic int idle_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] pick_sample(int lo, int w, int spill);
    int v;
    if ($urandom_range(0, 19) == 0) return ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7fff;
    v = lo - spill + int'($urandom_range(0, w + 2 * spill));
    if (v < -32768) v = -32768;
    if (v > 32767) v = 32767;
    return v[15:0];
  endfunction

  task automatic send_word(logic [OP_BITS-1:0] op, logic [15:0] smp, logic typed, nresult_t want);
    nresult_t r;
    int       gap;
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = smp;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = calc_normalized(op, smp);
    exp_fifo[exp_wr % EXP_DEPTH] = typed ? want : r;
    exp_wr++;
    if (op != OP_RESERVED) words_sent++;
    gap = idle_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      in_tdata  = 16'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic stop_input();
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic drain();
    while (exp_wr != exp_rd) @(negedge clk);
  endtask

  // result side: random stalls plus one long hold-off on request
  initial begin
    int stall_left;
    int hold_left;
    int holds_seen;
    stall_left = 0;
    hold_left  = 0;
    holds_seen = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != holds_seen) begin
        holds_seen = hold_reqs;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready = 1'b0;
      end else if (rx_stall_on && $urandom_range(0, 7) == 0) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        out_tready = 1'b0;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    nresult_t want;
    nresult_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[15:0], out_tdata[31:16], out_tdata[47:32], out_tuser};
      if (exp_wr == exp_rd) begin
        $display("%0t: unexpected word norm=%h min=%h range=%h degen=%b",
                 $time, got.norm, got.min_v, got.range_v, got.degen);
        mismatches++;
      end else begin
        want = exp_fifo[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (got.norm !== want.norm) begin
          $display("%0t: normalized expected %h actual %h", $time, want.norm, got.norm);
          mismatches++;
        end
        if (got.min_v !== want.min_v) begin
          $display("%0t: min_value expected %h actual %h", $time, want.min_v, got.min_v);
          mismatches++;
        end
        if (got.range_v !== want.range_v) begin
          $display("%0t: range_value expected %h actual %h", $time, want.range_v, got.range_v);
          mismatches++;
        end
        if (got.degen !== want.degen) begin
          $display("%0t: degenerate expected %b actual %b", $time, want.degen, got.degen);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int          i;
    int          k;
    int          n;
    int          kind;
    int          win_lo;
    int          win_w;
    bit          held;
    bit          paused;
    logic [15:0] smp;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = OP_CLEAR;
    rst_n       = 1'b0;
    idle_on     = 1'b0;
    rx_stall_on = 1'b0;
    hold_reqs   = 0;
    mismatches  = 0;
    words_sent  = 0;
    cycle_cnt   = 0;
    exp_wr      = 0;
    exp_rd      = 0;
    lo_seen     = '0;
    hi_seen     = '0;
    seen_any    = 1'b0;
    held        = 1'b0;
    paused      = 1'b0;
    dir_rows = '{
      '{OP_NORMALIZE, 16'h0000, 1'b1, '{16'h0000, 16'h0000, 16'h0000, 1'b1}},
      '{OP_RESERVED,  16'h1234, 1'b1, '{16'h0000, 16'h0000, 16'h0000, 1'b0}},
      '{OP_MEASURE,   16'h8000, 1'b1, '{16'h0000, 16'h8000, 16'h0000, 1'b0}},
      '{OP_NORMALIZE, 16'h0005, 1'b1, '{16'h0000, 16'h8000, 16'h0000, 1'b1}},
      '{OP_MEASURE,   16'h7fff, 1'b1, '{16'h0000, 16'h8000, 16'hffff, 1'b0}},
      '{OP_NORMALIZE, 16'h8000, 1'b1, '{16'h0000, 16'h8000, 16'hffff, 1'b0}},
      '{OP_NORMALIZE, 16'h7fff, 1'b1, '{16'hffff, 16'h8000, 16'hffff, 1'b0}},
      '{OP_NORMALIZE, 16'h0000, 1'b1, '{16'h8000, 16'h8000, 16'hffff, 1'b0}},
      '{OP_RESERVED,  16'hffff, 1'b1, '{16'h0000, 16'h8000, 16'hffff, 1'b0}},
      '{OP_CLEAR,     16'h5555, 1'b1, '{16'h0000, 16'h0000, 16'h0000, 1'b0}},
      '{OP_NORMALIZE, 16'haaaa, 1'b1, '{16'h0000, 16'h0000, 16'h0000, 1'b1}},
      '{OP_MEASURE,   16'd100,  1'b1, '{16'h0000, 16'd100,  16'h0000, 1'b0}},
      '{OP_MEASURE,   16'd200,  1'b1, '{16'h0000, 16'd100,  16'd100,  1'b0}},
      '{OP_NORMALIZE, 16'd50,   1'b1, '{16'h0000, 16'd100,  16'd100,  1'b0}},
      '{OP_NORMALIZE, 16'd300,  1'b1, '{16'hffff, 16'd100,  16'd100,  1'b0}},
      '{OP_NORMALIZE, 16'd150,  1'b1, '{16'h7fff, 16'd100,  16'd100,  1'b0}},
      '{OP_NORMALIZE, 16'd100,  1'b1, '{16'h0000, 16'd100,  16'd100,  1'b0}},
      '{OP_NORMALIZE, 16'd200,  1'b1, '{16'hffff, 16'd100,  16'd100,  1'b0}},
      '{OP_MEASURE,   16'hffff, 1'b0, '0},
      '{OP_NORMALIZE, 16'd17,   1'b0, '0},
      '{OP_NORMALIZE, 16'hffff, 1'b0, '0},
      '{OP_CLEAR,     16'h0000, 1'b1, '{16'h0000, 16'h0000, 16'h0000, 1'b0}},
      '{OP_MEASURE,   16'h0f0f, 1'b0, '0},
      '{OP_MEASURE,   16'hf0f0, 1'b0, '0},
      '{OP_NORMALIZE, 16'h0001, 1'b0, '0}
    };
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    for (i = 0; i < DIR_ROWS; i++)
      send_word(dir_rows[i].op, dir_rows[i].smp, dir_rows[i].typed, dir_rows[i].want);
    stop_input();
    drain();

    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      idle_on     = ($urandom_range(0, 3) != 0);
      rx_stall_on = idle_on || ($urandom_range(0, 1) != 0);
      // long hold-off at the result side while words keep coming
      if (!held && words_sent > 300) begin
        held    = 1'b1;
        idle_on = 1'b0;
        hold_reqs++;
        for (k = 0; k < 12; k++) send_word(OP_NORMALIZE, 16'($urandom), 1'b0, '0);
      end
      // sender pause until everything is back
      if (!paused && words_sent > 600) begin
        paused = 1'b1;
        stop_input();
        drain();
        repeat (30) @(negedge clk);
      end
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        if ($urandom_range(0, 3) != 0) send_word(OP_CLEAR, 16'($urandom), 1'b0, '0);
        case ($urandom_range(0, 2))
          0:       win_w = $urandom_range(1, 16);
          1:       win_w = $urandom_range(17, 4096);
          default: win_w = $urandom_range(4097, 65535);
        endcase
        win_lo = int'($urandom_range(0, 65535)) - 32768;
        if (win_lo + win_w > 32767) win_lo = 32767 - win_w;
        n = $urandom_range(1, 10);
        for (k = 0; k < n; k++) begin
          send_word(OP_MEASURE, pick_sample(win_lo, win_w, 0), 1'b0, '0);
          if ($urandom_range(0, 15) == 0) send_word(OP_RESERVED, 16'($urandom), 1'b0, '0);
        end
        n = $urandom_range(1, 12);
        for (k = 0; k < n; k++) begin
          if ($urandom_range(0, 4) == 0) smp = 16'($urandom);
          else smp = pick_sample(win_lo, win_w, win_w / 4 + 1);
          send_word(OP_NORMALIZE, smp, 1'b0, '0);
        end
      end else if (kind == 7) begin
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++)
          send_word(OP_BITS'($urandom_range(0, 3)), 16'($urandom), 1'b0, '0);
      end else if (kind == 8) begin
        send_word(OP_CLEAR, 16'($urandom), 1'b0, '0);
        n = $urandom_range(1, 3);
        for (k = 0; k < n; k++) send_word(OP_NORMALIZE, 16'($urandom), 1'b0, '0);
      end else begin
        // zero range: one value measured repeatedly
        send_word(OP_CLEAR, 16'($urandom), 1'b0, '0);
        smp = 16'($urandom);
        n = $urandom_range(1, 3);
        for (k = 0; k < n; k++) send_word(OP_MEASURE, smp, 1'b0, '0);
        n = $urandom_range(1, 3);
        for (k = 0; k < n; k++) send_word(OP_NORMALIZE, smp + 16'($urandom_range(0, 2)) - 16'd1,
                                          1'b0, '0);
      end
    end
    stop_input();
    drain();
    repeat (40) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASS min_max_normalizer");
    end else begin
      $display("FAIL min_max_normalizer");
    end
    $finish;
  end

endmodule
